// ===== src/bud_pkg.sv =====
package bud_pkg;

   localparam int MEM_ORDER = 10;
   localparam int MASK_W    = MEM_ORDER + 1;
   localparam int NODE_W    = MEM_ORDER + 1;
   localparam int NODES     = 1 << NODE_W;
   localparam int ORD_W     = $clog2(MEM_ORDER + 1);
   localparam int SORD_W    = 5;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [1:0] STATUS_TOO_BIG = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [15:0] request_size;
      logic [31:0] block_address;
   } bud_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted_address;
   } bud_rsp_type;

   // ceil(log2(size)), size 0 and 1 give 0
   function automatic logic [SORD_W-1:0] size_order(input logic [15:0] size);
      logic [15:0]       v;
      logic [SORD_W-1:0] k;
      v = size - 16'd1;
      k = '0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) k = SORD_W'(i + 1);
      end
      if (size <= 16'd1) k = '0;
      return k;
   endfunction

   function automatic logic [ORD_W-1:0] lowest_set(input logic [MASK_W-1:0] m);
      logic [ORD_W-1:0] o;
      o = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (m[i]) o = ORD_W'(i);
      end
      return o;
   endfunction

endpackage

// ===== src/buddy_allocator.sv =====
// Allocate: a root check, one search or split step per level down to the requested order,
// then a start step and two climb steps (sibling, parent) per level up to the root; free: a
// start step, two climb steps per level, one fix step per merge. Rejects go to the response;
// a stalled result port holds it back. One request at a time: req_stall is high until idle.
// Each cycle does at most one read and one write of the per-node summary memory.
// Reset: synchronous; a clearing pass over every node leaves only the root free, requests stalled.
module buddy_allocator (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bud_pkg::bud_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bud_pkg::bud_rsp_type rsp_data
);
   import bud_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ROOT  = 4'd2;
   localparam logic [3:0] S_DESC  = 4'd3;
   localparam logic [3:0] S_SPLIT = 4'd4;
   localparam logic [3:0] S_START = 4'd5;
   localparam logic [3:0] S_SIB   = 4'd6;
   localparam logic [3:0] S_PAR   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;
   localparam logic [3:0] S_FIX   = 4'd9;

   // each entry: bit o set when the subtree holds a free block of order o
   logic [MASK_W-1:0] map_mem [NODES];
   logic [MASK_W-1:0] rd_data_ff;
   logic [NODE_W-1:0] rd_addr, wr_addr;
   logic [MASK_W-1:0] wr_data;
   logic              wr_en;

   logic [3:0]        state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [31:0]       base_ff;
   logic              op_ff, op_in;
   logic [ORD_W-1:0]  k_ff, k_in, tgt_ff, tgt_in, ord_ff, ord_in;
   logic [NODE_W-1:0] node_ff, node_in, found_ff, found_in;
   logic [MASK_W-1:0] cm_ff, cm_in, ms_ff, ms_in;
   logic              merge_ff, merge_in;
   logic [1:0]        status_ff, status_in;
   logic [31:0]       addr_ff, addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bud_rsp_type       rsp_data_ff, rsp_data_in;

   logic [SORD_W-1:0] req_k;
   logic [31:0]       fr_off;
   logic              fr_bad;
   logic [NODE_W-1:0] fr_node;
   logic [MASK_W-1:0] root_avail;
   logic [NODE_W-1:0] left_c, c_node, parent, sibling;
   logic [ORD_W-1:0]  c_ord, p_ord;
   logic              go_br, sib_free;
   logic [MASK_W-1:0] own_p;
   logic [MEM_ORDER-1:0] al_off;

   assign req_k   = size_order(req_data.request_size);
   assign fr_off  = req_data.block_address - base_ff;
   assign fr_bad  = (req_k > SORD_W'(MEM_ORDER)) || (req_data.block_address < base_ff) ||
                    (|fr_off[31:MEM_ORDER]) || (|(fr_off & ~(32'hFFFF_FFFF << req_k)));
   assign fr_node = NODE_W'((32'd1 << (MEM_ORDER - int'(req_k))) | (fr_off >> req_k));

   assign root_avail = rd_data_ff & ~((MASK_W'(1) << k_ff) - MASK_W'(1));
   assign left_c     = {node_ff[NODE_W-2:0], 1'b0};
   assign parent     = {1'b0, node_ff[NODE_W-1:1]};
   assign sibling    = {node_ff[NODE_W-1:1], ~node_ff[0]};
   assign p_ord      = ord_ff + ORD_W'(1);
   assign al_off     = MEM_ORDER'(node_ff << k_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) map_mem[wr_addr] <= wr_data;
      rd_data_ff <= map_mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      tgt_in       = tgt_ff;
      ord_in       = ord_ff;
      node_in      = node_ff;
      found_in     = found_ff;
      cm_in        = cm_ff;
      ms_in        = ms_ff;
      merge_in     = merge_ff;
      status_in    = status_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = node_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = cm_ff;
      go_br        = 1'b0;
      c_node       = node_ff;
      c_ord        = ord_ff;
      sib_free     = 1'b0;
      own_p        = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == NODE_W'(1)) ? (MASK_W'(1) << MEM_ORDER) : '0;
            clr_in  = clr_ff + NODE_W'(1);
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.operation;
               k_in      = ORD_W'(req_k);
               status_in = STATUS_OK;
               addr_in   = '0;
               if (req_data.operation == OP_ALLOC) begin
                  if (req_k > SORD_W'(MEM_ORDER)) begin
                     status_in = STATUS_TOO_BIG;
                     state_in  = S_RESP;
                  end else begin
                     rd_addr  = NODE_W'(1);
                     state_in = S_ROOT;
                  end
               end else if (fr_bad) begin
                  status_in = STATUS_IGNORED;
                  state_in  = S_RESP;
               end else begin
                  node_in  = fr_node;
                  ord_in   = ORD_W'(req_k);
                  rd_addr  = fr_node;
                  state_in = S_START;
               end
            end
         end
         S_ROOT: begin
            if (root_avail == '0) begin
               status_in = STATUS_NO_FREE;
               state_in  = S_RESP;
            end else begin
               tgt_in = lowest_set(root_avail);
               if (lowest_set(root_avail) == ORD_W'(MEM_ORDER)) begin
                  go_br    = 1'b1;
                  c_node   = NODE_W'(1);
                  c_ord    = ORD_W'(MEM_ORDER);
                  found_in = NODE_W'(1);
               end else begin
                  node_in  = NODE_W'(1);
                  ord_in   = ORD_W'(MEM_ORDER);
                  rd_addr  = NODE_W'(2);
                  state_in = S_DESC;
               end
            end
         end
         S_DESC: begin
            // leftmost subtree holding the target order wins
            c_node = rd_data_ff[tgt_ff] ? left_c : (left_c | NODE_W'(1));
            c_ord  = ord_ff - ORD_W'(1);
            if (c_ord == tgt_ff) begin
               go_br    = 1'b1;
               found_in = c_node;
            end else begin
               node_in = c_node;
               ord_in  = c_ord;
               rd_addr = {c_node[NODE_W-2:0], 1'b0};
            end
         end
         S_SPLIT: begin
            // right half becomes free, keep going down the left half
            wr_en   = 1'b1;
            wr_addr = left_c | NODE_W'(1);
            wr_data = rd_data_ff | (MASK_W'(1) << (ord_ff - ORD_W'(1)));
            go_br   = 1'b1;
            c_node  = left_c;
            c_ord   = ord_ff - ORD_W'(1);
         end
         S_START: begin
            if (op_ff == OP_ALLOC) begin
               cm_in   = rd_data_ff & ~(MASK_W'(1) << k_ff);
               addr_in = base_ff + 32'(al_off);
            end else begin
               cm_in    = rd_data_ff | (MASK_W'(1) << k_ff);
               merge_in = 1'b1;
            end
            wr_en   = 1'b1;
            wr_data = cm_in;
            if (node_ff == NODE_W'(1)) begin
               state_in = S_RESP;
            end else begin
               rd_addr  = sibling;
               state_in = S_SIB;
            end
         end
         S_SIB: begin
            sib_free = (op_ff == OP_FREE) && merge_ff && rd_data_ff[ord_ff];
            ms_in    = rd_data_ff;
            merge_in = sib_free;
            if (sib_free) begin
               ms_in    = rd_data_ff & ~(MASK_W'(1) << ord_ff);
               cm_in    = cm_ff & ~(MASK_W'(1) << ord_ff);
               wr_en    = 1'b1;
               wr_addr  = sibling;
               wr_data  = ms_in;
               state_in = S_FIX;
            end else begin
               rd_addr  = parent;
               state_in = S_PAR;
            end
         end
         S_FIX: begin
            // merged node loses its own free bit in the memory as well
            wr_en    = 1'b1;
            rd_addr  = parent;
            state_in = S_PAR;
         end
         S_PAR: begin
            own_p = rd_data_ff & (MASK_W'(1) << p_ord);
            if (op_ff == OP_ALLOC && parent == found_ff) own_p = '0;
            if (merge_ff) own_p = MASK_W'(1) << p_ord;
            cm_in   = own_p | cm_ff | ms_ff;
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = cm_in;
            node_in = parent;
            ord_in  = p_ord;
            if (parent == NODE_W'(1)) begin
               state_in = S_RESP;
            end else begin
               rd_addr  = {parent[NODE_W-1:1], ~parent[0]};
               state_in = S_SIB;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = status_ff;
               rsp_data_in.granted_address = (status_ff == STATUS_OK) ? addr_ff : '0;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // found block: split it down to the requested order, or start the climb
      if (go_br) begin
         node_in  = c_node;
         ord_in   = c_ord;
         if (c_ord > k_ff) begin
            rd_addr  = {c_node[NODE_W-2:0], 1'b1};
            state_in = S_SPLIT;
         end else begin
            rd_addr  = c_node;
            state_in = S_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
      op_ff       <= op_in;
      k_ff        <= k_in;
      tgt_ff      <= tgt_in;
      ord_ff      <= ord_in;
      node_ff     <= node_in;
      found_ff    <= found_in;
      cm_ff       <= cm_in;
      ms_ff       <= ms_in;
      merge_ff    <= merge_in;
      status_ff   <= status_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
